>>> rtl/gbfs_pkg.sv
// shared constants and controller/datapath link types for the path walk unit
`timescale 1ns / 1ps
`default_nettype none

package gbfs_pkg;

    localparam int NODES     = 8;
    localparam int MAX_NODES = 8;
    localparam int NODE_W    = 3;
    localparam int HEUR_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ADJACENCY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEURISTICS = 1'b1;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/gbfs_dp.sv
// datapath: config registers, walk state, neighbour search and output payload
`timescale 1ns / 1ps
`default_nettype none

module gbfs_dp
    import gbfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic [NODE_W-1:0]     i_start_node,
    input  wire logic [NODE_W-1:0]     i_goal_node,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic [NODE_W-1:0]          o_node,
    output logic                       o_last,
    output logic                       o_dead_end
);

    logic [CFG_W-1:0]     r_adj;
    logic [CFG_W-1:0]     r_heur;
    logic [NODE_W-1:0]    r_cur;
    logic [NODE_W-1:0]    r_goal;
    logic [MAX_NODES-1:0] r_visited;
    logic [NODE_W-1:0]    r_count;
    logic [NODE_W-1:0]    r_out_node;
    logic                 r_out_last;
    logic                 r_out_dead;

    logic [MAX_NODES-1:0] w_row;
    logic [NODE_W-1:0]    w_best;
    logic [HEUR_W-1:0]    w_best_h;
    logic                 w_found;
    logic                 w_last;
    logic                 w_dead;

    // neighbour search: least heuristic, strict compare keeps lowest index on ties
    always_comb begin
        w_row    = r_adj[{r_cur, 3'b000} +: MAX_NODES];
        w_best   = '0;
        w_best_h = '0;
        w_found  = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            if (w_row[i] && !r_visited[i]) begin
                if (!w_found || (r_heur[i*HEUR_W +: HEUR_W] < w_best_h)) begin
                    w_best   = NODE_W'(i);
                    w_best_h = r_heur[i*HEUR_W +: HEUR_W];
                    w_found  = 1'b1;
                end
            end
        end
    end

    assign w_last = (r_cur == r_goal) || !w_found || (r_count == NODE_W'(MAX_NODES - 1));
    assign w_dead = w_last && (r_cur != r_goal);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj  <= '0;
            r_heur <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ADJACENCY:  r_adj  <= i_cfg_data;
                REG_HEURISTICS: r_heur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur     <= i_start_node;
            r_goal    <= i_goal_node;
            r_visited <= MAX_NODES'(1) << i_start_node;
            r_count   <= '0;
        end else if (i_cmd.emit) begin
            r_out_node <= r_cur;
            r_out_last <= w_last;
            r_out_dead <= w_dead;
            if (!w_last) begin
                r_cur     <= w_best;
                r_visited <= r_visited | (MAX_NODES'(1) << w_best);
                r_count   <= r_count + NODE_W'(1);
            end
        end
    end

    assign o_sts.last = w_last;
    assign o_node     = r_out_node;
    assign o_last     = r_out_last;
    assign o_dead_end = r_out_dead;

endmodule

`default_nettype wire

>>> rtl/gbfs_ctrl.sv
// controller: run sequencing and output word valid
`timescale 1ns / 1ps
`default_nettype none

module gbfs_ctrl
    import gbfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free   = !r_out_valid || i_out_ready;
    // no word is taken while reset is held
    assign o_in_ready   = i_rst_n && (r_state == ST_IDLE);
    assign o_cmd.load   = i_in_valid && o_in_ready;
    assign o_cmd.emit   = (r_state == ST_RUN) && w_out_free;
    assign o_out_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (i_sts.last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN))
        else $error("accepted word did not start a run");

    a_no_load_and_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.emit))
        else $error("load and emit in the same cycle");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("final word did not end the run");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && !i_sts.last) |=> (r_state == ST_RUN) && r_out_valid)
        else $error("emitted word lost mid-run");

endmodule

`default_nettype wire

>>> rtl/greedy_best_first_path_walk_unit.sv
// the first path word is emitted into the output register after the request word loads the walk state
// throughput: one path word per cycle while the output is taken; the input side is held
// for the whole run, which visits at most 8 nodes, with one neighbour search a hop
// the final word may wait in the output register while the next request is accepted
// reset: synchronous active low, clears adjacency and heuristics to zero and idles
// top level: greedy best-first path walk over an eight-node graph
`timescale 1ns / 1ps
`default_nettype none

module greedy_best_first_path_walk_unit
    import gbfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // start_node[2:0], goal_node[5:3]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // node[2:0]
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser    // dead_end[0]
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [NODE_W-1:0] w_node;

    assign o_cfg_ready = i_rst_n;

    gbfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    gbfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start_node (s_axis_tdata[NODE_W-1:0]),
        .i_goal_node  (s_axis_tdata[2*NODE_W-1:NODE_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_node       (w_node),
        .o_last       (m_axis_tlast),
        .o_dead_end   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-NODE_W){1'b0}}, w_node};

endmodule

`default_nettype wire
